>>> hw/rtl/quaternion_vector_rotate_unit_defines.svh
// Assertion macros used by the file that checks the rotate unit.
`ifndef QUATERNION_VECTOR_ROTATE_UNIT_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QVR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QVR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/qvr_pkg.sv
package qvr_pkg;

  localparam int IN_W       = 16;
  localparam int PRD_W      = 32;
  localparam int MAT_W      = 35;
  localparam int MV_W       = 51;
  localparam int N_W        = 53;
  localparam int NUM_W      = 63;
  localparam int DEN_W      = 33;
  localparam int REM_W      = 34;
  localparam int Q_W        = 31;
  localparam int T_W        = 29;
  localparam int ROOT_W     = 16;
  localparam int SQ_W       = 32;
  localparam int CS_W       = 17;
  localparam int TERM_W     = 46;
  localparam int ACC_W      = 48;
  localparam int SAT_W      = 25;
  localparam int OUT_W      = 21;
  localparam int OUT_LIMIT  = 908096;
  localparam int NPRD       = 10;
  localparam int NMAT       = 9;
  localparam int NDIV       = 5;
  localparam int NSQ        = 2;
  localparam int DIV_STAGES = 31;
  localparam int SQ_STAGES  = 16;

  localparam int LANE_TX = 0;
  localparam int LANE_TY = 1;
  localparam int LANE_TZ = 2;
  localparam int LANE_C  = 3;
  localparam int LANE_S  = 4;

  typedef struct packed {
    logic       inval;
    logic       wneg;
    logic [2:0] nneg;
  } div_side_t;

  typedef struct packed {
    logic                  inval;
    logic                  wneg;
    logic signed [T_W-1:0] tx;
    logic signed [T_W-1:0] ty;
    logic signed [T_W-1:0] tz;
  } sq_side_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] res;
    res = v;
    if (v > SAT_W'(OUT_LIMIT)) begin
      res = SAT_W'(OUT_LIMIT);
    end else if (v < -SAT_W'(OUT_LIMIT)) begin
      res = -SAT_W'(OUT_LIMIT);
    end
    return res[OUT_W-1:0];
  endfunction

endpackage

>>> hw/rtl/qvr_front.sv
module qvr_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [qvr_pkg::IN_W-1:0]     quat_w,
  input  logic signed [qvr_pkg::IN_W-1:0]     quat_x,
  input  logic signed [qvr_pkg::IN_W-1:0]     quat_y,
  input  logic signed [qvr_pkg::IN_W-1:0]     quat_z,
  input  logic signed [qvr_pkg::IN_W-1:0]     vec_x,
  input  logic signed [qvr_pkg::IN_W-1:0]     vec_y,
  input  logic signed [qvr_pkg::IN_W-1:0]     vec_z,
  output logic                                out_valid,
  output logic [qvr_pkg::NUM_W-1:0]           out_num [qvr_pkg::NDIV],
  output logic [qvr_pkg::DEN_W-1:0]           out_den,
  output qvr_pkg::div_side_t                  out_side
);

  logic                                 vld1_r, vld2_r, vld3_r, vld4_r;
  logic                                 inval1_r, inval2_r, inval3_r;
  logic                                 wneg1_r, wneg2_r, wneg3_r;
  logic signed [qvr_pkg::PRD_W-1:0]     p1_r [qvr_pkg::NPRD];
  logic signed [qvr_pkg::PRD_W-1:0]     p1_nxt [qvr_pkg::NPRD];
  logic signed [qvr_pkg::IN_W-1:0]      v1_r [3];
  logic signed [qvr_pkg::IN_W-1:0]      v2_r [3];
  logic signed [qvr_pkg::MAT_W-1:0]     m2_r [qvr_pkg::NMAT];
  logic signed [qvr_pkg::MAT_W-1:0]     m2_nxt [qvr_pkg::NMAT];
  logic [qvr_pkg::DEN_W-1:0]            s2_r, s2_nxt, s3_r;
  logic [qvr_pkg::PRD_W-1:0]            ww2_r, ww3_r;
  logic signed [qvr_pkg::MV_W-1:0]      mv3_r [qvr_pkg::NMAT];
  logic signed [qvr_pkg::MV_W-1:0]      mv3_nxt [qvr_pkg::NMAT];
  logic [qvr_pkg::NUM_W-1:0]            num4_r [qvr_pkg::NDIV];
  logic [qvr_pkg::NUM_W-1:0]            num4_nxt [qvr_pkg::NDIV];
  logic [qvr_pkg::DEN_W-1:0]            den4_r;
  qvr_pkg::div_side_t                   side4_r, side4_nxt;

  always_comb begin
    p1_nxt[0] = qvr_pkg::PRD_W'(quat_w * quat_w);
    p1_nxt[1] = qvr_pkg::PRD_W'(quat_x * quat_x);
    p1_nxt[2] = qvr_pkg::PRD_W'(quat_y * quat_y);
    p1_nxt[3] = qvr_pkg::PRD_W'(quat_z * quat_z);
    p1_nxt[4] = qvr_pkg::PRD_W'(quat_x * quat_y);
    p1_nxt[5] = qvr_pkg::PRD_W'(quat_x * quat_z);
    p1_nxt[6] = qvr_pkg::PRD_W'(quat_y * quat_z);
    p1_nxt[7] = qvr_pkg::PRD_W'(quat_x * quat_w);
    p1_nxt[8] = qvr_pkg::PRD_W'(quat_y * quat_w);
    p1_nxt[9] = qvr_pkg::PRD_W'(quat_z * quat_w);
  end

  always_comb begin
    logic signed [qvr_pkg::MAT_W-1:0] e [qvr_pkg::NPRD];
    logic signed [qvr_pkg::MAT_W-1:0] s_all;
    for (int i = 0; i < qvr_pkg::NPRD; i++) begin
      e[i] = qvr_pkg::MAT_W'(p1_r[i]);
    end
    s_all = e[0] + e[1] + e[2] + e[3];
    s2_nxt = s_all[qvr_pkg::DEN_W-1:0];
    m2_nxt[0] = s_all - 2 * e[2] - 2 * e[3];
    m2_nxt[1] = 2 * (e[4] - e[9]);
    m2_nxt[2] = 2 * (e[5] + e[8]);
    m2_nxt[3] = 2 * (e[4] + e[9]);
    m2_nxt[4] = s_all - 2 * e[3] - 2 * e[1];
    m2_nxt[5] = 2 * (e[6] - e[7]);
    m2_nxt[6] = 2 * (e[5] - e[8]);
    m2_nxt[7] = 2 * (e[6] + e[7]);
    m2_nxt[8] = s_all - 2 * e[2] - 2 * e[1];
  end

  always_comb begin
    for (int i = 0; i < qvr_pkg::NMAT; i++) begin
      mv3_nxt[i] = qvr_pkg::MV_W'(m2_r[i] * qvr_pkg::MV_W'(v2_r[i % 3]));
    end
  end

  always_comb begin
    logic signed [qvr_pkg::N_W-1:0] n;
    logic [qvr_pkg::N_W-1:0]        mag;
    side4_nxt.inval = inval3_r;
    side4_nxt.wneg  = wneg3_r;
    for (int r = 0; r < 3; r++) begin
      n = qvr_pkg::N_W'(mv3_r[3*r]) + qvr_pkg::N_W'(mv3_r[3*r+1])
        + qvr_pkg::N_W'(mv3_r[3*r+2]);
      side4_nxt.nneg[r] = n[qvr_pkg::N_W-1];
      mag = n[qvr_pkg::N_W-1] ? qvr_pkg::N_W'(-n) : qvr_pkg::N_W'(n);
      num4_nxt[r] = (qvr_pkg::NUM_W'(mag) << 12) + qvr_pkg::NUM_W'(s3_r >> 1);
    end
    num4_nxt[qvr_pkg::LANE_C] = qvr_pkg::NUM_W'(ww3_r) << 30;
    num4_nxt[qvr_pkg::LANE_S] = qvr_pkg::NUM_W'(s3_r - qvr_pkg::DEN_W'(ww3_r)) << 30;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r     <= p1_nxt;
      v1_r[0]  <= vec_x;
      v1_r[1]  <= vec_y;
      v1_r[2]  <= vec_z;
      inval1_r <= (quat_w == '0) && (quat_x == '0) && (quat_y == '0) && (quat_z == '0);
      wneg1_r  <= quat_w[qvr_pkg::IN_W-1];
      m2_r     <= m2_nxt;
      s2_r     <= s2_nxt;
      ww2_r    <= p1_r[0];
      v2_r     <= v1_r;
      inval2_r <= inval1_r;
      wneg2_r  <= wneg1_r;
      mv3_r    <= mv3_nxt;
      s3_r     <= s2_r;
      ww3_r    <= ww2_r;
      inval3_r <= inval2_r;
      wneg3_r  <= wneg2_r;
      num4_r   <= num4_nxt;
      den4_r   <= s3_r;
      side4_r  <= side4_nxt;
    end
  end

  assign out_valid = vld4_r;
  assign out_num   = num4_r;
  assign out_den   = den4_r;
  assign out_side  = side4_r;

endmodule

>>> hw/rtl/qvr_div.sv
module qvr_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [qvr_pkg::NUM_W-1:0]   in_num [qvr_pkg::NDIV],
  input  logic [qvr_pkg::DEN_W-1:0]   in_den,
  input  qvr_pkg::div_side_t          in_side,
  output logic                        out_valid,
  output logic [qvr_pkg::Q_W-1:0]     out_q [qvr_pkg::NDIV],
  output qvr_pkg::div_side_t          out_side
);

  localparam int NS = qvr_pkg::DIV_STAGES;

  logic [qvr_pkg::REM_W-1:0] rem_r   [NS][qvr_pkg::NDIV];
  logic [qvr_pkg::REM_W-1:0] rem_nxt [NS][qvr_pkg::NDIV];
  logic [qvr_pkg::Q_W-1:0]   q_r     [NS][qvr_pkg::NDIV];
  logic [qvr_pkg::Q_W-1:0]   q_nxt   [NS][qvr_pkg::NDIV];
  logic [qvr_pkg::Q_W-1:0]   lo_r    [NS][qvr_pkg::NDIV];
  logic [qvr_pkg::Q_W-1:0]   lo_nxt  [NS][qvr_pkg::NDIV];
  logic [qvr_pkg::DEN_W-1:0] den_r   [NS];
  qvr_pkg::div_side_t        side_r  [NS];
  logic [NS-1:0]             vld_r;

  always_comb begin
    logic [qvr_pkg::REM_W-1:0] prem;
    logic [qvr_pkg::Q_W-1:0]   pq;
    logic [qvr_pkg::Q_W-1:0]   plo;
    logic [qvr_pkg::DEN_W-1:0] d;
    logic [qvr_pkg::REM_W-1:0] trial;
    logic                      ge;
    for (int k = 0; k < NS; k++) begin
      for (int l = 0; l < qvr_pkg::NDIV; l++) begin
        if (k == 0) begin
          prem = qvr_pkg::REM_W'(in_num[l][qvr_pkg::NUM_W-1:qvr_pkg::Q_W]);
          pq   = '0;
          plo  = in_num[l][qvr_pkg::Q_W-1:0];
          d    = in_den;
        end else begin
          prem = rem_r[k-1][l];
          pq   = q_r[k-1][l];
          plo  = lo_r[k-1][l];
          d    = den_r[k-1];
        end
        trial         = {prem[qvr_pkg::REM_W-2:0], plo[qvr_pkg::Q_W-1]};
        ge            = trial >= qvr_pkg::REM_W'(d);
        rem_nxt[k][l] = ge ? trial - qvr_pkg::REM_W'(d) : trial;
        q_nxt[k][l]   = {pq[qvr_pkg::Q_W-2:0], ge};
        lo_nxt[k][l]  = {plo[qvr_pkg::Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r     <= rem_nxt;
      q_r       <= q_nxt;
      lo_r      <= lo_nxt;
      den_r[0]  <= in_den;
      side_r[0] <= in_side;
      for (int k = 1; k < NS; k++) begin
        den_r[k]  <= den_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_q     = q_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

>>> hw/rtl/qvr_isqrt.sv
module qvr_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [qvr_pkg::Q_W-1:0]     in_rad [qvr_pkg::NSQ],
  input  qvr_pkg::sq_side_t           in_side,
  output logic                        out_valid,
  output logic [qvr_pkg::ROOT_W-1:0]  out_root [qvr_pkg::NSQ],
  output qvr_pkg::sq_side_t           out_side
);

  localparam int NS = qvr_pkg::SQ_STAGES;

  logic [qvr_pkg::SQ_W-1:0] n_r     [NS][qvr_pkg::NSQ];
  logic [qvr_pkg::SQ_W-1:0] n_nxt   [NS][qvr_pkg::NSQ];
  logic [qvr_pkg::SQ_W-1:0] res_r   [NS][qvr_pkg::NSQ];
  logic [qvr_pkg::SQ_W-1:0] res_nxt [NS][qvr_pkg::NSQ];
  qvr_pkg::sq_side_t        side_r  [NS];
  logic [NS-1:0]            vld_r;

  always_comb begin
    logic [qvr_pkg::SQ_W-1:0] pn;
    logic [qvr_pkg::SQ_W-1:0] pres;
    logic [qvr_pkg::SQ_W-1:0] bitv;
    for (int k = 0; k < NS; k++) begin
      bitv = qvr_pkg::SQ_W'(1) << (2 * (NS - 1 - k));
      for (int l = 0; l < qvr_pkg::NSQ; l++) begin
        if (k == 0) begin
          pn   = qvr_pkg::SQ_W'(in_rad[l]);
          pres = '0;
        end else begin
          pn   = n_r[k-1][l];
          pres = res_r[k-1][l];
        end
        if (pn >= pres + bitv) begin
          n_nxt[k][l]   = pn - (pres + bitv);
          res_nxt[k][l] = (pres >> 1) + bitv;
        end else begin
          n_nxt[k][l]   = pn;
          res_nxt[k][l] = pres >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r       <= n_nxt;
      res_r     <= res_nxt;
      side_r[0] <= in_side;
      for (int k = 1; k < NS; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < qvr_pkg::NSQ; l++) begin
      out_root[l] = res_r[NS-1][l][qvr_pkg::ROOT_W-1:0];
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

>>> hw/rtl/qvr_post.sv
module qvr_post (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [qvr_pkg::ROOT_W-1:0]        in_root [qvr_pkg::NSQ],
  input  qvr_pkg::sq_side_t                 in_side,
  output logic                              out_valid,
  output logic signed [qvr_pkg::OUT_W-1:0]  out_x,
  output logic signed [qvr_pkg::OUT_W-1:0]  out_y,
  output logic signed [qvr_pkg::OUT_W-1:0]  out_z,
  output logic                              quat_invalid
);

  logic                                 vld1_r, vld2_r;
  logic                                 inval1_r;
  logic signed [qvr_pkg::CS_W-1:0]      c_r, s_r;
  logic signed [qvr_pkg::T_W-1:0]       tx1_r, ty1_r, tz1_r;
  logic signed [qvr_pkg::TERM_W-1:0]    sx_r, cy_r, cx_r, sy_r;
  logic signed [qvr_pkg::SAT_W-1:0]     z2_r, z2_nxt;
  logic                                 inval2_r;
  logic signed [qvr_pkg::OUT_W-1:0]     x3_r, y3_r, z3_r, x3_nxt, y3_nxt, z3_nxt;
  logic                                 vld3_r, inval3_r;
  logic signed [qvr_pkg::CS_W-1:0]      c_nxt, s_nxt;

  always_comb begin
    logic signed [qvr_pkg::CS_W-1:0] cm;
    cm    = $signed({1'b0, in_root[0]});
    c_nxt = in_side.wneg ? -cm : cm;
    s_nxt = $signed({1'b0, in_root[1]});
  end

  always_comb begin
    logic signed [qvr_pkg::T_W:0] zr;
    zr     = qvr_pkg::T_W'(tz1_r) + (qvr_pkg::T_W+1)'(128);
    z2_nxt = qvr_pkg::SAT_W'(zr >>> 8);
  end

  always_comb begin
    logic signed [qvr_pkg::ACC_W-1:0] ax;
    logic signed [qvr_pkg::ACC_W-1:0] ay;
    ax = qvr_pkg::ACC_W'(sx_r) + qvr_pkg::ACC_W'(cy_r) + (qvr_pkg::ACC_W'(1) <<< 22);
    ay = qvr_pkg::ACC_W'(cx_r) - qvr_pkg::ACC_W'(sy_r) + (qvr_pkg::ACC_W'(1) <<< 22);
    if (inval2_r) begin
      x3_nxt = '0;
      y3_nxt = '0;
      z3_nxt = '0;
    end else begin
      x3_nxt = qvr_pkg::sat_out(qvr_pkg::SAT_W'(ax >>> 23));
      y3_nxt = qvr_pkg::sat_out(qvr_pkg::SAT_W'(ay >>> 23));
      z3_nxt = qvr_pkg::sat_out(z2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r      <= c_nxt;
      s_r      <= s_nxt;
      tx1_r    <= in_side.tx;
      ty1_r    <= in_side.ty;
      tz1_r    <= in_side.tz;
      inval1_r <= in_side.inval;
      sx_r     <= qvr_pkg::TERM_W'(s_r * qvr_pkg::TERM_W'(tx1_r));
      cy_r     <= qvr_pkg::TERM_W'(c_r * qvr_pkg::TERM_W'(ty1_r));
      cx_r     <= qvr_pkg::TERM_W'(c_r * qvr_pkg::TERM_W'(tx1_r));
      sy_r     <= qvr_pkg::TERM_W'(s_r * qvr_pkg::TERM_W'(ty1_r));
      z2_r     <= z2_nxt;
      inval2_r <= inval1_r;
      x3_r     <= x3_nxt;
      y3_r     <= y3_nxt;
      z3_r     <= z3_nxt;
      inval3_r <= inval2_r;
    end
  end

  assign out_valid    = vld3_r;
  assign out_x        = x3_r;
  assign out_y        = y3_r;
  assign out_z        = z3_r;
  assign quat_invalid = inval3_r;

endmodule

>>> hw/rtl/quaternion_vector_rotate_unit.sv
// Channel  | Direction | tdata (low bit up)                              | tuser
// in_      | input     | quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z | none
// out_     | output    | out_x, out_y, out_z, one zero pad bit           | quat_invalid
//
// A beat is accepted every cycle while the output is not stalled.
// Each beat runs through the front end, the 31-stage pipelined divider, the 16-stage square root and the post stage.
// The synchronous active-low reset clears only the valid bits of every stage.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`include "quaternion_vector_rotate_unit_defines.svh"

module quaternion_vector_rotate_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [111:0]  in_tdata,   // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [63:0]   out_tdata,  // out_x, out_y, out_z, pad
  output logic [0:0]    out_tuser   // quat_invalid
);

  logic                               en;
  logic                               f_valid, d_valid, q_valid, p_valid;
  logic [qvr_pkg::NUM_W-1:0]          f_num [qvr_pkg::NDIV];
  logic [qvr_pkg::DEN_W-1:0]          f_den;
  qvr_pkg::div_side_t                 f_side, d_side;
  logic [qvr_pkg::Q_W-1:0]            d_q [qvr_pkg::NDIV];
  logic [qvr_pkg::Q_W-1:0]            rad [qvr_pkg::NSQ];
  qvr_pkg::sq_side_t                  sq_side, q_side;
  logic [qvr_pkg::ROOT_W-1:0]         q_root [qvr_pkg::NSQ];
  logic signed [qvr_pkg::OUT_W-1:0]   res_x, res_y, res_z;
  logic                               res_inval;

  assign en        = !p_valid || out_tready;
  assign in_tready = en;

  qvr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .quat_w    (in_tdata[15:0]),
    .quat_x    (in_tdata[31:16]),
    .quat_y    (in_tdata[47:32]),
    .quat_z    (in_tdata[63:48]),
    .vec_x     (in_tdata[79:64]),
    .vec_y     (in_tdata[95:80]),
    .vec_z     (in_tdata[111:96]),
    .out_valid (f_valid),
    .out_num   (f_num),
    .out_den   (f_den),
    .out_side  (f_side)
  );

  qvr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .in_num    (f_num),
    .in_den    (f_den),
    .in_side   (f_side),
    .out_valid (d_valid),
    .out_q     (d_q),
    .out_side  (d_side)
  );

  always_comb begin
    logic signed [qvr_pkg::T_W-1:0] m [3];
    for (int r = 0; r < 3; r++) begin
      m[r] = $signed({1'b0, d_q[r][qvr_pkg::T_W-2:0]});
      if (d_side.nneg[r]) begin
        m[r] = -m[r];
      end
    end
    sq_side.inval = d_side.inval;
    sq_side.wneg  = d_side.wneg;
    sq_side.tx    = m[0];
    sq_side.ty    = m[1];
    sq_side.tz    = m[2];
    rad[0]        = d_q[qvr_pkg::LANE_C];
    rad[1]        = d_q[qvr_pkg::LANE_S];
  end

  qvr_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d_valid),
    .in_rad    (rad),
    .in_side   (sq_side),
    .out_valid (q_valid),
    .out_root  (q_root),
    .out_side  (q_side)
  );

  qvr_post u_post (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (q_valid),
    .in_root      (q_root),
    .in_side      (q_side),
    .out_valid    (p_valid),
    .out_x        (res_x),
    .out_y        (res_y),
    .out_z        (res_z),
    .quat_invalid (res_inval)
  );

  assign out_tvalid = p_valid;
  assign out_tdata  = {1'b0, res_z, res_y, res_x};
  assign out_tuser  = res_inval;

  `QVR_ASSERT_NOW(a_invalid_zero, clk, rst_n, out_tvalid && out_tuser[0], out_tdata == '0, "invalid quaternion must give zero outputs")
  `QVR_ASSERT_NOW(a_x_range, clk, rst_n, out_tvalid, (res_x <= 21'sd908096) && (res_x >= -21'sd908096), "out_x outside saturation range")
  `QVR_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "pipeline moved during output stall")

endmodule
